[design/bblur_pkg.sv]
package bblur_pkg;

	localparam int CFG_W = 11;
	localparam int CHAN_W = 8;
	localparam int PIX_W = 3 * CHAN_W;
	localparam int SUM_W = 12;
	localparam int NUM_W = 13;
	localparam int RECIP_W = 16;
	localparam int PROD_W = NUM_W + RECIP_W;

	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_word_t;

	typedef struct packed {
		logic [7:0] blur_red;
		logic [7:0] blur_green;
		logic [7:0] blur_blue;
		logic       frame_last;
	} blur_word_t;

	typedef enum logic {
		ST_FILL,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic emit;
		logic drain;
		logic up_ok;
		logic dn_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} ctrl_cmd_t;

	// Reciprocal of twice the neighbour count, scaled by 2^16 and rounded down.
	function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] cnt);
		logic [RECIP_W-1:0] m;
		unique case (cnt)
			4'd1:    m = 16'd32768;
			4'd2:    m = 16'd16384;
			4'd3:    m = 16'd10922;
			4'd4:    m = 16'd8192;
			4'd6:    m = 16'd5461;
			4'd9:    m = 16'd3640;
			default: m = 16'd0;
		endcase
		return m;
	endfunction

endpackage

[design/bblur_ctrl.sv]
module bblur_ctrl import bblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	input  logic             command,
	input  logic             advance,
	output logic             pixel_stall,
	output ctrl_cmd_t        cmd,
	output logic [AW-1:0]    wr_col
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 2);
	localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
	localparam int CHW = (HW > CFG_W) ? HW : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CWW-1:0]   wide_w;
	logic [CHW-1:0]   wide_h;
	logic [WW-1:0]    w_eff;
	logic [HW-1:0]    h_eff;

	logic [AW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [AW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	logic in_col_end;
	logic fill_end;
	logic out_col_end;
	logic out_row_end;

	always_comb begin
		wide_w = CWW'(width_q);
		if (wide_w == '0) begin
			w_eff = WW'(1);
		end else if (wide_w > CWW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = wide_w[WW-1:0];
		end
	end

	always_comb begin
		wide_h = CHW'(height_q);
		if (wide_h == '0) begin
			h_eff = HW'(1);
		end else if (wide_h > CHW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = wide_h[HW-1:0];
		end
	end

	assign in_col_end = (WW'(in_col_q) + WW'(1)) == w_eff;
	assign fill_end = (in_row_q == RW'(1)) && (in_col_q == '0);
	assign out_col_end = (WW'(out_col_q) + WW'(1)) == w_eff;
	assign out_row_end = (out_row_q + HW'(1)) == h_eff;

	assign pixel_stall = !advance;
	assign wr_col = in_col_q;

	always_comb begin
		cmd.take = pixel_valid && advance;
		cmd.emit = (state_q == ST_RUN);
		cmd.drain = (command == CMD_DRAIN) || (in_row_q >= RW'(h_eff));
		cmd.up_ok = (out_row_q != '0);
		cmd.dn_ok = (out_row_q + HW'(1)) < h_eff;
		cmd.left_ok = (out_col_q != '0);
		cmd.right_ok = !out_col_end;
		cmd.last = (state_q == ST_RUN) && out_row_end && out_col_end;

		state_d = state_q;
		if (cfg_write) begin
			state_d = ST_FILL;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (cmd.take && fill_end) begin
						state_d = ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.take && cmd.last) begin
						state_d = ST_FILL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1024);
			height_q <= CFG_W'(1024);
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
			endcase
			in_col_q <= '0;
			in_row_q <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cmd.take) begin
			if (cmd.last) begin
				in_col_q <= '0;
				in_row_q <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= in_col_q + AW'(1);
				end
				if (cmd.emit) begin
					if (out_col_end) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HW'(1);
					end else begin
						out_col_q <= out_col_q + AW'(1);
					end
				end
			end
		end
	end

endmodule

[design/bblur_datapath.sv]
module bblur_datapath import bblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	input  logic [AW-1:0]    wr_col,
	input  logic [PIX_W-1:0] pixel_rgb,
	input  logic             blur_stall,
	output logic             advance,
	output logic             blur_valid,
	output blur_word_t       blur_word
);

	logic [PIX_W-1:0] line_a_mem [MAX_WIDTH];
	logic [PIX_W-1:0] line_b_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_q [3][3];

	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ctrl_cmd_t        cmd_s1, cmd_s2, cmd_s3;
	logic [PIX_W-1:0] pix_s1, pix_s2;
	logic [PIX_W-1:0] rda_s1, rda_s2;
	logic [PIX_W-1:0] rdb_s2;
	logic [AW-1:0]    col_s1;

	logic [NUM_W-1:0]   x_s4 [3];
	logic [NUM_W-1:0]   x_s5 [3];
	logic [RECIP_W-1:0] m_s4;
	logic [4:0]         d_s4, d_s5;
	logic               last_s4, last_s5;
	logic [PROD_W-1:0]  prod_s5 [3];

	logic [PIX_W-1:0] pix_in;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [1:0]       rows;
	logic [1:0]       cols;
	logic [3:0]       cnt;
	logic [SUM_W-1:0] sum [3];
	logic [CHAN_W-1:0] q0 [3];
	logic [NUM_W-1:0]  qd [3];
	logic [NUM_W-1:0]  rem [3];
	logic [CHAN_W-1:0] avg [3];

	logic             blur_valid_q;
	blur_word_t       blur_word_q;

	assign advance = !blur_valid_q || !blur_stall;
	assign blur_valid = blur_valid_q;
	assign blur_word = blur_word_q;
	assign pix_in = cmd.drain ? '0 : pixel_rgb;

	// The newest row store yields the word one row back; its old contents
	// move on into the second store, which yields the word two rows back.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rda_s1 <= line_a_mem[wr_col];
			line_a_mem[wr_col] <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			rdb_s2 <= line_b_mem[col_s1];
			line_b_mem[col_s1] <= rda_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_s1 <= pix_in;
			col_s1 <= wr_col;
			cmd_s1 <= cmd;
			pix_s2 <= pix_s1;
			rda_s2 <= rda_s1;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s2) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= rdb_s2;
			win_q[1][2] <= rda_s2;
			win_q[2][2] <= pix_s2;
		end
	end

	always_comb begin
		row_ok = {cmd_s3.dn_ok, 1'b1, cmd_s3.up_ok};
		col_ok = {cmd_s3.right_ok, 1'b1, cmd_s3.left_ok};
		rows = 2'd1 + 2'(cmd_s3.up_ok) + 2'(cmd_s3.dn_ok);
		cols = 2'd1 + 2'(cmd_s3.left_ok) + 2'(cmd_s3.right_ok);
		cnt = 4'(rows) * 4'(cols);
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (row_ok[r] && col_ok[c]) begin
						sum[ch] = sum[ch] + SUM_W'(win_q[r][c][CHAN_W*ch +: CHAN_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int ch = 0; ch < 3; ch++) begin
				x_s4[ch] <= {sum[ch], 1'b0} + NUM_W'(cnt);
				x_s5[ch] <= x_s4[ch];
				prod_s5[ch] <= PROD_W'(x_s4[ch]) * PROD_W'(m_s4);
			end
			m_s4 <= recip_of(cnt);
			d_s4 <= {cnt, 1'b0};
			d_s5 <= d_s4;
			last_s4 <= cmd_s3.last;
			last_s5 <= last_s4;
		end
	end

	// The scaled reciprocal gives the quotient or one less; one compare fixes it.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			q0[ch] = prod_s5[ch][RECIP_W +: CHAN_W];
			qd[ch] = NUM_W'(q0[ch]) * NUM_W'(d_s5);
			rem[ch] = x_s5[ch] - qd[ch];
			avg[ch] = (rem[ch] >= NUM_W'(d_s5)) ? q0[ch] + CHAN_W'(1) : q0[ch];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			blur_word_q.blur_red <= avg[2];
			blur_word_q.blur_green <= avg[1];
			blur_word_q.blur_blue <= avg[0];
			blur_word_q.frame_last <= last_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			blur_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s1 <= cmd.take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3 && cmd_s3.emit;
			vld_s5 <= vld_s4;
			blur_valid_q <= vld_s5;
		end
	end

endmodule

[design/box_blur_3x3_edge_average.sv]
// Accepts one word per clock while the result side is not stalled.
// The word that completes a pixel's window arrives image_width+1 words later; once taken,
// its result moves through the s1, s2, window, sum and product registers to the output.
// The pipeline holds as a whole whenever the output register is full and stalled.
// Reset clears the counters, the pipeline valid bits and sets both dimensions to 1024;
// the row stores are not cleared.
module box_blur_3x3_edge_average import bblur_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  pixel_word_t      pixel_word,
	output logic             blur_valid,
	input  logic             blur_stall,
	output blur_word_t       blur_word
);

	localparam int AW = $clog2(MAX_WIDTH);

	ctrl_cmd_t     cmd;
	logic [AW-1:0] wr_col;
	logic          advance;

	bblur_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.command     (pixel_word.command),
		.advance     (advance),
		.pixel_stall (pixel_stall),
		.cmd         (cmd),
		.wr_col      (wr_col)
	);

	bblur_datapath #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.wr_col     (wr_col),
		.pixel_rgb  ({pixel_word.red, pixel_word.green, pixel_word.blue}),
		.blur_stall (blur_stall),
		.advance    (advance),
		.blur_valid (blur_valid),
		.blur_word  (blur_word)
	);

endmodule

[sim/tb_top.sv]
module tb_top;
	import bblur_pkg::*;

	localparam int MAX_W = 1024;
	localparam int MAX_H = 1024;
	localparam int HIST_DEPTH = 2 * MAX_W + 3;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_WORDS = 300;

	typedef enum logic {
		ROW_CFG,
		ROW_WORD
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic             cfg_reg;
		logic [CFG_W-1:0] cfg_val;
		pixel_word_t      word;
		logic             typed;
		blur_word_t       want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [0:35] = '{
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'h5a, 8'ha5, 8'h3c}, 1'b0, '0},
		'{ROW_CFG, REG_IMAGE_WIDTH, 11'd1, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 11'd1, '0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd0, 8'd0, 8'd0}, 1'b1,
			'{8'd255, 8'd255, 8'd255, 1'b1}},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd77, 8'd88, 8'd99}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd12, 8'd34, 8'd56}, 1'b1,
			'{8'd0, 8'd0, 8'd0, 1'b1}},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd1, 8'd2, 8'd3}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd200, 8'd100, 8'd50}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd9, 8'd9, 8'd9}, 1'b1,
			'{8'd1, 8'd2, 8'd3, 1'b1}},
		'{ROW_CFG, REG_IMAGE_WIDTH, 11'd0, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 11'd0, '0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd128, 8'd64, 8'd32}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b1,
			'{8'd128, 8'd64, 8'd32, 1'b1}},
		'{ROW_CFG, REG_IMAGE_WIDTH, 11'd2, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 11'd1, '0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd255, 8'd0, 8'd1}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd0, 8'd255, 8'd2}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b1,
			'{8'd128, 8'd128, 8'd2, 1'b0}},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b1,
			'{8'd128, 8'd128, 8'd2, 1'b1}},
		'{ROW_CFG, REG_IMAGE_WIDTH, 11'd3, '0, 1'b0, '0},
		'{ROW_CFG, REG_IMAGE_HEIGHT, 11'd2, '0, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd255, 8'd0, 8'd255}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_PIXEL, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
		'{ROW_WORD, 1'b0, 11'd0, '{CMD_DRAIN, 8'd0, 8'd0, 8'd0}, 1'b0, '0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic             cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             pixel_valid = 1'b0;
	logic             pixel_stall;
	pixel_word_t      pixel_word = '0;
	logic             blur_valid;
	logic             blur_stall = 1'b0;
	blur_word_t       blur_word;

	logic [CFG_W-1:0] img_w_raw = 11'd1024;
	logic [CFG_W-1:0] img_h_raw = 11'd1024;
	logic [PIX_W-1:0] pix_hist [HIST_DEPTH];
	int unsigned      hist_ptr = 0;
	int unsigned      out_col = 0;
	int unsigned      out_row = 0;
	int unsigned      frame_words = 0;

	blur_word_t       blur_due [$];
	int unsigned      words_sent = 0;
	int unsigned      bad_words = 0;
	int unsigned      cycle_count = 0;
	int unsigned      stall_left = 0;
	bit               steady_in = 1'b0;
	bit               steady_out = 1'b0;

	box_blur_3x3_edge_average #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_word(pixel_word),
		.blur_valid(blur_valid),
		.blur_stall(blur_stall),
		.blur_word(blur_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned dim_of(input logic [CFG_W-1:0] raw, input int unsigned cap);
		if (raw == 0) begin
			return 1;
		end
		if (raw > cap) begin
			return cap;
		end
		return raw;
	endfunction

	function automatic void restart_frame();
		hist_ptr = 0;
		out_col = 0;
		out_row = 0;
		frame_words = 0;
	endfunction

	function automatic bit blur_predict(input pixel_word_t w, output blur_word_t res);
		int unsigned      wd, ht, total, n, back, slot, cnt;
		int unsigned      sum_r, sum_g, sum_b;
		int               dr, dc;
		logic [PIX_W-1:0] pix;
		bit               row_ok, col_ok;
		wd = dim_of(img_w_raw, MAX_W);
		ht = dim_of(img_h_raw, MAX_H);
		total = wd * ht;
		n = frame_words;
		pix = (w.command == CMD_DRAIN || n >= total) ? '0 : {w.red, w.green, w.blue};
		pix_hist[hist_ptr] = pix;
		res = '0;
		if (n < wd + 1) begin
			frame_words = n + 1;
			hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
			return 1'b0;
		end
		sum_r = 0;
		sum_g = 0;
		sum_b = 0;
		cnt = 0;
		for (dr = -1; dr <= 1; dr++) begin
			for (dc = -1; dc <= 1; dc++) begin
				row_ok = (dr == 0) || (dr < 0 ? out_row >= 1 : out_row + 1 < ht);
				col_ok = (dc == 0) || (dc < 0 ? out_col >= 1 : out_col + 1 < wd);
				if (row_ok && col_ok) begin
					back = wd + 1;
					if (dr < 0) back += wd;
					if (dr > 0) back -= wd;
					if (dc < 0) back += 1;
					if (dc > 0) back -= 1;
					slot = (hist_ptr + HIST_DEPTH - back) % HIST_DEPTH;
					sum_r += pix_hist[slot][23:16];
					sum_g += pix_hist[slot][15:8];
					sum_b += pix_hist[slot][7:0];
					cnt++;
				end
			end
		end
		res.blur_red = 8'((2 * sum_r + cnt) / (2 * cnt));
		res.blur_green = 8'((2 * sum_g + cnt) / (2 * cnt));
		res.blur_blue = 8'((2 * sum_b + cnt) / (2 * cnt));
		res.frame_last = (n - wd >= total);
		if (res.frame_last) begin
			restart_frame();
		end else begin
			frame_words = n + 1;
			hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
			if (out_col + 1 >= wd) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end
		return 1'b1;
	endfunction

	// Mostly short runs, now and then a long one.
	function automatic int unsigned run_length();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 24);
	endfunction

	function automatic logic [7:0] rand_chan();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			return 8'd0;
		end
		if (pick < 20) begin
			return 8'd255;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic take_result(input blur_word_t got);
		blur_word_t want;
		if (blur_due.size() == 0) begin
			bad_words++;
			if (bad_words <= 10) begin
				$display("unexpected word at cycle %0d: %h %h %h last %b", cycle_count,
					got.blur_red, got.blur_green, got.blur_blue, got.frame_last);
			end
		end else begin
			want = blur_due.pop_front();
			if (got.blur_red !== want.blur_red || got.blur_green !== want.blur_green ||
					got.blur_blue !== want.blur_blue || got.frame_last !== want.frame_last) begin
				bad_words++;
				if (bad_words <= 10) begin
					$display("mismatch at cycle %0d: expected %h %h %h last %b, got %h %h %h last %b",
						cycle_count, want.blur_red, want.blur_green, want.blur_blue,
						want.frame_last, got.blur_red, got.blur_green, got.blur_blue,
						got.frame_last);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (blur_valid && !blur_stall) begin
			take_result(blur_word);
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			blur_stall <= 1'b1;
		end else if (!steady_out && $urandom_range(0, 99) < 20) begin
			stall_left <= run_length() - 1;
			blur_stall <= 1'b1;
		end else begin
			blur_stall <= 1'b0;
		end
	end

	task automatic send_word(input pixel_word_t w, input bit typed, input blur_word_t want);
		int unsigned gap;
		bit          has;
		blur_word_t  res;
		gap = (steady_in || $urandom_range(0, 99) < 65) ? 0 : run_length();
		if (gap != 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_word <= w;
		do @(posedge clk); while (pixel_stall);
		has = blur_predict(w, res);
		if (typed) begin
			blur_due.push_back(want);
		end else if (has) begin
			blur_due.push_back(res);
		end
		words_sent++;
	endtask

	// The pipeline may still hold words that give no result, hence the settle time.
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		while (blur_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) begin
			img_w_raw = val;
		end else begin
			img_h_raw = val;
		end
		restart_frame();
	endtask

	task automatic send_frame(input int unsigned wd, input int unsigned ht,
			input int unsigned count);
		pixel_word_t w;
		int unsigned i;
		for (i = 0; i < count; i++) begin
			if (i < wd * ht) begin
				w.command = ($urandom_range(0, 99) < 3) ? CMD_DRAIN : CMD_PIXEL;
			end else begin
				w.command = ($urandom_range(0, 9) == 0) ? CMD_PIXEL : CMD_DRAIN;
			end
			w.red = rand_chan();
			w.green = rand_chan();
			w.blue = rand_chan();
			send_word(w, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
			input int unsigned frames, input bit partial);
		int unsigned wd, ht;
		steady_in = ($urandom_range(0, 3) == 0);
		steady_out = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_IMAGE_WIDTH, w_raw);
			write_reg(REG_IMAGE_HEIGHT, h_raw);
		end else begin
			write_reg(REG_IMAGE_HEIGHT, h_raw);
			write_reg(REG_IMAGE_WIDTH, w_raw);
		end
		wd = dim_of(w_raw, MAX_W);
		ht = dim_of(h_raw, MAX_H);
		repeat (frames) send_frame(wd, ht, wd * ht + wd + 1);
		if (partial) begin
			send_frame(wd, ht, $urandom_range(1, wd * ht + wd));
		end
	endtask

	initial begin
		int unsigned      sel, total, frames, first;
		bit               partial;
		logic [CFG_W-1:0] w_raw, h_raw;
		foreach (pix_hist[i]) pix_hist[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_reg(DIRECTED[i].cfg_reg, DIRECTED[i].cfg_val);
			end else begin
				send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
			end
		end
		// Saturating dimensions: the start of one full-width row, then one full-height column.
		run_phase(11'd2047, 11'd1, 0, 1'b0);
		send_frame(MAX_W, 1, MAX_W + 6);
		run_phase(11'd1, 11'd2047, 1, 1'b0);
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			partial = 1'b0;
			if (sel < 65) begin
				w_raw = 11'($urandom_range(1, 12));
				h_raw = 11'($urandom_range(1, 8));
			end else if (sel < 75) begin
				w_raw = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1, 4));
				h_raw = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'($urandom_range(1, 4));
			end else if (sel < 85) begin
				w_raw = 11'($urandom_range(1, 4));
				h_raw = 11'($urandom_range(20, 60));
			end else if (sel < 93) begin
				w_raw = 11'($urandom_range(30, 100));
				h_raw = 11'($urandom_range(1, 3));
			end else begin
				w_raw = 11'($urandom_range(1, 8));
				h_raw = 11'($urandom_range(1, 6));
				partial = 1'b1;
			end
			total = dim_of(w_raw, MAX_W) * dim_of(h_raw, MAX_H);
			frames = (total > 300) ? 1 : $urandom_range(1, 3);
			if (total <= 300 && $urandom_range(0, 99) < 15) begin
				partial = 1'b1;
			end
			run_phase(w_raw, h_raw, frames, partial);
		end
		wait_idle();
		if (bad_words == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
design/bblur_pkg.sv
design/bblur_ctrl.sv
design/bblur_datapath.sv
design/box_blur_3x3_edge_average.sv
sim/tb_top.sv
